[src/pklp_pkg.sv]
// shared types, constants and command/status structs for the port-keyed probe table
package pklp_pkg;

    // table geometry; the slot count is a power of two so the home slot is the low port bits
    localparam int TABLE_SIZE  = 1024;
    localparam int PROBE_LIMIT = 16;
    localparam int SLOT_W      = $clog2(TABLE_SIZE);
    localparam int PROBE_W     = $clog2(PROBE_LIMIT + 1);

    // field widths
    localparam int PORT_W = 16;
    localparam int PID_W  = 32;
    localparam int APP_W  = 9;
    localparam int STAT_W = 2;
    localparam int OP_W   = 2;

    // application index meaning none
    localparam logic [APP_W-1:0] APP_NONE = {APP_W{1'b1}};

    // request codes
    typedef enum logic [OP_W-1:0] {
        REQ_SET   = 2'd0,
        REQ_GET   = 2'd1,
        REQ_CLEAR = 2'd2
    } req_type_t;

    // result codes
    typedef enum logic [STAT_W-1:0] {
        RES_OK   = 2'd0,
        RES_MISS = 2'd1,
        RES_FULL = 2'd2
    } res_status_t;

    // one table slot as held in memory
    typedef struct packed {
        logic              valid;
        logic [PORT_W-1:0] port;
        logic [PID_W-1:0]  pid;
        logic [APP_W-1:0]  app;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // controller states
    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_ISSUE,
        S_PROBE,
        S_DONE
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic        req_load;
        logic        sweep_step;
        logic        probe_step;
        logic        wr_set;
        logic        wr_kill;
        logic        res_load;
        res_status_t res_status;
        logic        res_hit;
        logic        out_load;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic            sweep_last;
        logic            probe_last;
        logic [OP_W-1:0] op;
        logic            slot_valid;
        logic            slot_match;
    } dp_stat_t;

endpackage

[src/pklp_req_if.sv]
// request channel: handshake and request fields
interface pklp_req_if;
    logic                             valid;
    logic                             ready;
    logic [pklp_pkg::OP_W-1:0]        req_type;
    logic [pklp_pkg::PORT_W-1:0]      port;
    logic [pklp_pkg::PID_W-1:0]       owner_pid;
    logic signed [pklp_pkg::APP_W-1:0] app_index;

    modport source (output valid, output req_type, output port, output owner_pid,
                    output app_index, input ready);
    modport sink   (input valid, input req_type, input port, input owner_pid,
                    input app_index, output ready);
endinterface

[src/pklp_rsp_if.sv]
// result channel: handshake and result fields
interface pklp_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [pklp_pkg::STAT_W-1:0]       status;
    logic signed [pklp_pkg::APP_W-1:0] found_app_index;
    logic [pklp_pkg::PID_W-1:0]        found_pid;

    modport source (output valid, output status, output found_app_index,
                    output found_pid, input ready);
    modport sink   (input valid, input status, input found_app_index,
                    input found_pid, output ready);
endinterface

[src/pklp_ram.sv]
// generic single-write, single-read memory with registered read data
module pklp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/pklp_datapath.sv]
// datapath: request registers, probe address and count, slot memory, result registers
module pklp_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [pklp_pkg::OP_W-1:0]         req_type,
    input  logic [pklp_pkg::PORT_W-1:0]       port,
    input  logic [pklp_pkg::PID_W-1:0]        owner_pid,
    input  logic [pklp_pkg::APP_W-1:0]        app_index,
    input  pklp_pkg::dp_cmd_t                 cmd,
    output pklp_pkg::dp_stat_t                stat,
    output logic [pklp_pkg::STAT_W-1:0]       status,
    output logic [pklp_pkg::APP_W-1:0]        found_app_index,
    output logic [pklp_pkg::PID_W-1:0]        found_pid
);

    logic [pklp_pkg::OP_W-1:0]    op_reg;
    logic [pklp_pkg::PORT_W-1:0]  port_reg;
    logic [pklp_pkg::PID_W-1:0]   pid_reg;
    logic [pklp_pkg::APP_W-1:0]   app_reg;
    logic [pklp_pkg::SLOT_W-1:0]  slot_reg;
    logic [pklp_pkg::SLOT_W-1:0]  slot_next;
    logic [pklp_pkg::PROBE_W-1:0] count_reg;
    logic [pklp_pkg::SLOT_W-1:0]  sweep_reg;

    logic [pklp_pkg::STAT_W-1:0]  res_status_reg;
    logic [pklp_pkg::APP_W-1:0]   res_app_reg;
    logic [pklp_pkg::PID_W-1:0]   res_pid_reg;
    logic [pklp_pkg::STAT_W-1:0]  out_status_reg;
    logic [pklp_pkg::APP_W-1:0]   out_app_reg;
    logic [pklp_pkg::PID_W-1:0]   out_pid_reg;

    logic                             ram_we;
    logic [pklp_pkg::SLOT_W-1:0]      ram_waddr;
    pklp_pkg::entry_t                 ram_wdata;
    logic [pklp_pkg::SLOT_W-1:0]      ram_raddr;
    logic [pklp_pkg::ENTRY_W-1:0]     ram_rdata;
    pklp_pkg::entry_t                 rd_entry;

    // request capture and probe walk; the table wraps naturally at its power-of-two size
    assign slot_next = slot_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (cmd.req_load)
        begin
            op_reg    <= req_type;
            port_reg  <= port;
            pid_reg   <= owner_pid;
            app_reg   <= app_index;
            slot_reg  <= port[pklp_pkg::SLOT_W-1:0];
            count_reg <= '0;
        end
        else if (cmd.probe_step)
        begin
            slot_reg  <= slot_next;
            count_reg <= count_reg + 1'b1;
        end
    end

    // clearing sweep address after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg <= '0;
        end
        else if (cmd.sweep_step)
        begin
            sweep_reg <= sweep_reg + 1'b1;
        end
    end

    // memory access: the next slot is read while the current one is examined
    always_comb
    begin
        ram_we          = cmd.sweep_step | cmd.wr_set | cmd.wr_kill;
        ram_waddr       = cmd.sweep_step ? sweep_reg : slot_reg;
        ram_wdata       = '0;
        if (cmd.wr_set)
        begin
            ram_wdata.valid = 1'b1;
            ram_wdata.port  = port_reg;
            ram_wdata.pid   = pid_reg;
            ram_wdata.app   = app_reg;
        end
        ram_raddr       = cmd.probe_step ? slot_next : slot_reg;
    end

    pklp_ram #(
        .WIDTH (pklp_pkg::ENTRY_W),
        .DEPTH (pklp_pkg::TABLE_SIZE)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry = pklp_pkg::entry_t'(ram_rdata);

    // status towards the controller
    always_comb
    begin
        stat.sweep_last = (sweep_reg == pklp_pkg::SLOT_W'(pklp_pkg::TABLE_SIZE - 1));
        stat.probe_last = (count_reg == pklp_pkg::PROBE_W'(pklp_pkg::PROBE_LIMIT - 1));
        stat.op         = op_reg;
        stat.slot_valid = rd_entry.valid;
        stat.slot_match = (rd_entry.port == port_reg);
    end

    // pending result, then output register
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_status;
            res_app_reg    <= cmd.res_hit ? rd_entry.app : pklp_pkg::APP_NONE;
            res_pid_reg    <= cmd.res_hit ? rd_entry.pid : '0;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_app_reg    <= res_app_reg;
            out_pid_reg    <= res_pid_reg;
        end
    end

    assign status          = out_status_reg;
    assign found_app_index = out_app_reg;
    assign found_pid       = out_pid_reg;

endmodule

[src/pklp_ctrl.sv]
// controller: clearing sweep, request sequencing and result handshake
module pklp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    input  pklp_pkg::dp_stat_t stat,
    output pklp_pkg::dp_cmd_t  cmd
);

    pklp_pkg::state_t state_reg;
    pklp_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    // state and output-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pklp_pkg::S_SWEEP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.res_status = pklp_pkg::RES_MISS;
        req_ready      = 1'b0;
        out_valid_next = out_valid_reg & ~rsp_ready;

        case (state_reg)
            pklp_pkg::S_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = pklp_pkg::S_IDLE;
                end
            end

            pklp_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.req_load = 1'b1;
                    state_next   = pklp_pkg::S_ISSUE;
                end
            end

            pklp_pkg::S_ISSUE:
            begin
                state_next = pklp_pkg::S_PROBE;
            end

            pklp_pkg::S_PROBE:
            begin
                case (stat.op)
                    pklp_pkg::REQ_SET:
                    begin
                        if (!stat.slot_valid || stat.slot_match)
                        begin
                            cmd.wr_set     = 1'b1;
                            cmd.res_load   = 1'b1;
                            cmd.res_status = pklp_pkg::RES_OK;
                            state_next     = pklp_pkg::S_DONE;
                        end
                        else if (stat.probe_last)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = pklp_pkg::RES_FULL;
                            state_next     = pklp_pkg::S_DONE;
                        end
                        else
                        begin
                            cmd.probe_step = 1'b1;
                        end
                    end

                    pklp_pkg::REQ_GET:
                    begin
                        if (stat.slot_valid && stat.slot_match)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = pklp_pkg::RES_OK;
                            cmd.res_hit    = 1'b1;
                            state_next     = pklp_pkg::S_DONE;
                        end
                        else if (!stat.slot_valid || stat.probe_last)
                        begin
                            cmd.res_load = 1'b1;
                            state_next   = pklp_pkg::S_DONE;
                        end
                        else
                        begin
                            cmd.probe_step = 1'b1;
                        end
                    end

                    pklp_pkg::REQ_CLEAR:
                    begin
                        // empty slots do not end the search
                        if (stat.slot_valid && stat.slot_match)
                        begin
                            cmd.wr_kill    = 1'b1;
                            cmd.res_load   = 1'b1;
                            cmd.res_status = pklp_pkg::RES_OK;
                            state_next     = pklp_pkg::S_DONE;
                        end
                        else if (stat.probe_last)
                        begin
                            cmd.res_load = 1'b1;
                            state_next   = pklp_pkg::S_DONE;
                        end
                        else
                        begin
                            cmd.probe_step = 1'b1;
                        end
                    end

                    default:
                    begin
                        // unused request code: no change, miss result
                        cmd.res_load = 1'b1;
                        state_next   = pklp_pkg::S_DONE;
                    end
                endcase
            end

            pklp_pkg::S_DONE:
            begin
                // hand the result over once the output register is free
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = pklp_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = pklp_pkg::S_IDLE;
            end
        endcase
    end

    assign rsp_valid = out_valid_reg;

endmodule

[src/port_keyed_linear_probe_table.sv]
// top level of the port-keyed linear-probe table
// Open-addressing table of 1024 slots keyed by a 16-bit port, held in one single-port-read
// memory of valid bit, port, pid and app index. After reset the block sweeps the memory,
// clearing every valid bit, and takes no request until the sweep is done. A request is then
// handled one at a time: the IDLE state accepts it, ISSUE reads the home slot, PROBE examines
// the probed slots in turn (1 to 16, one memory read each), and DONE passes the result to the
// output register once that register is free. The next request is accepted while the previous
// result still waits on the output.
module port_keyed_linear_probe_table (
    input  logic        clk,
    input  logic        rst_n,
    pklp_req_if.sink    req,
    pklp_rsp_if.source  rsp
);

    pklp_pkg::dp_cmd_t  cmd;
    pklp_pkg::dp_stat_t stat;
    logic [pklp_pkg::APP_W-1:0] found_app;

    // sequencing
    pklp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // storage and result path
    pklp_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_type        (req.req_type),
        .port            (req.port),
        .owner_pid       (req.owner_pid),
        .app_index       (req.app_index),
        .cmd             (cmd),
        .stat            (stat),
        .status          (rsp.status),
        .found_app_index (found_app),
        .found_pid       (rsp.found_pid)
    );

    assign rsp.found_app_index = found_app;

endmodule
